// ===== rtl/core/ptfe_pkg.sv =====
// Package for the programmable table FSM engine: sizes, opcodes, status codes,
// item/result records and the controller <-> datapath command/status structs.
// No dependencies.
package ptfe_pkg;

	localparam int STATE_SLOTS = 16;
	localparam int EVENT_SLOTS = 16;
	localparam int ACTION_BITS = 8;

	localparam int ID_W      = 32;
	localparam int LIM_W     = 5;
	localparam int ACT_IO_W  = 8;
	localparam int CFG_IDX_W = 2;

	localparam int SIDX_W   = $clog2(STATE_SLOTS);
	localparam int EIDX_W   = $clog2(EVENT_SLOTS);
	localparam int SCNT_W   = $clog2(STATE_SLOTS + 1);
	localparam int ECNT_W   = $clog2(EVENT_SLOTS + 1);
	localparam int TR_AW    = SIDX_W + EIDX_W;
	localparam int TR_DEPTH = 1 << TR_AW;

	typedef enum logic [1:0] {
		OP_REG_STATE = 2'd0,
		OP_REG_EVENT = 2'd1,
		OP_PROGRAM   = 2'd2,
		OP_DELIVER   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RS_DONE     = 2'd0,
		RS_UNKNOWN  = 2'd1,
		RS_FULL     = 2'd2,
		RS_NO_TRANS = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STATE_LIMIT = 2'd0,
		CFG_EVENT_LIMIT = 2'd1,
		CFG_INSTANCE_ID = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		op_t                   opcode;
		logic [ID_W-1:0]       state_code;
		logic [ID_W-1:0]       next_state_code;
		logic [ID_W-1:0]       event_code;
		logic                  make_initial;
		logic                  has_action;
		logic [ACT_IO_W-1:0]   action_code;
	} item_t;

	typedef struct packed {
		status_t               status;
		logic [ID_W-1:0]       present_id;
		logic                  action_fired;
		logic [ACT_IO_W-1:0]   fired_action;
		logic [ID_W-1:0]       machine_id;
		logic [ID_W-1:0]       event_echo;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // latch accepted item
		logic issue;   // register id lookup and transition read (deliver)
		logic commit;  // apply side effects, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_deliver;
	} sts_t;

endpackage

// ===== rtl/core/ptfe_if.sv =====
// Channel interfaces of the programmable table FSM engine: item input,
// result output and configuration write. Depends on ptfe_pkg.
interface ptfe_in_if;
	import ptfe_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic [ID_W-1:0]      state_code;
	logic [ID_W-1:0]      next_state_code;
	logic [ID_W-1:0]      event_code;
	logic                 make_initial;
	logic                 has_action;
	logic [ACT_IO_W-1:0]  action_code;

	modport source (output valid, opcode, state_code, next_state_code, event_code,
		make_initial, has_action, action_code, input ready);
	modport sink (input valid, opcode, state_code, next_state_code, event_code,
		make_initial, has_action, action_code, output ready);
endinterface

interface ptfe_out_if;
	import ptfe_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [ID_W-1:0]      present_id;
	logic                 action_fired;
	logic [ACT_IO_W-1:0]  fired_action;
	logic [ID_W-1:0]      machine_id;
	logic [ID_W-1:0]      event_echo;

	modport source (output valid, status, present_id, action_fired, fired_action,
		machine_id, event_echo, input ready);
	modport sink (input valid, status, present_id, action_fired, fired_action,
		machine_id, event_echo, output ready);
endinterface

interface ptfe_cfg_if;
	import ptfe_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [ID_W-1:0]       data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ptfe_ctrl.sv =====
// Controller of the programmable table FSM engine: sequences accept, lookup,
// transition read and result transfer. Depends on ptfe_pkg.
module ptfe_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output ptfe_pkg::cmd_t  cmd,
	input  ptfe_pkg::sts_t  sts
);
	import ptfe_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_READ
	} ctrl_state_t;

	ctrl_state_t state_q;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_LOOK: begin
				cmd.issue  = sts.is_deliver;
				cmd.commit = !sts.is_deliver && slot_free;
			end
			S_READ: cmd.commit = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_LOOK;
				S_LOOK: begin
					if (sts.is_deliver)
						state_q <= S_READ;
					else if (slot_free)
						state_q <= S_IDLE;
				end
				S_READ: if (slot_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/ptfe_dp.sv =====
// Datapath of the programmable table FSM engine: config registers, state and
// event id tables with parallel match, transition memory, result register.
// Depends on ptfe_pkg.
module ptfe_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptfe_pkg::cmd_t                 cmd,
	output ptfe_pkg::sts_t                 sts,
	input  ptfe_pkg::item_t                item,
	input  logic                           cfg_we,
	input  logic [ptfe_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [ptfe_pkg::ID_W-1:0]      cfg_data,
	output ptfe_pkg::result_t              res
);
	import ptfe_pkg::*;

	typedef struct packed {
		logic                    act_en;
		logic [ACTION_BITS-1:0]  act;
		logic [ID_W-1:0]         next;
	} tr_entry_t;

	item_t              item_q;
	logic [LIM_W-1:0]   st_lim_q;
	logic [LIM_W-1:0]   ev_lim_q;
	logic [ID_W-1:0]    inst_q;
	logic [ID_W-1:0]    st_tab_q [STATE_SLOTS];
	logic [ID_W-1:0]    ev_tab_q [EVENT_SLOTS];
	logic [SCNT_W-1:0]  st_used_q;
	logic [ECNT_W-1:0]  ev_used_q;
	logic [ID_W-1:0]    present_q;
	logic [TR_DEPTH-1:0] tr_vld_q;
	tr_entry_t          tr_mem [TR_DEPTH];
	tr_entry_t          rd_q;
	logic               rd_vld_q;
	logic               pair_hit_q;
	result_t            res_q;

	logic [ID_W-1:0]    key_a;
	logic               sa_hit, sb_hit, e_hit;
	logic [SIDX_W-1:0]  sa_idx;
	logic [EIDX_W-1:0]  e_idx;
	logic [TR_AW-1:0]   tr_addr;
	logic               st_full, ev_full;
	logic               st_wr, ev_wr, tr_wr;
	logic [ID_W-1:0]    pres_d;
	result_t            res_d;

	assign sts.is_deliver = (item_q.opcode == OP_DELIVER);
	assign res = res_q;

	// deliver looks up the present state, other opcodes the source state
	assign key_a = (item_q.opcode == OP_DELIVER) ? present_q : item_q.state_code;

	// first valid slot wins: scan downward so the lowest match is kept
	always_comb begin
		sa_hit = 1'b0;
		sb_hit = 1'b0;
		sa_idx = '0;
		for (int i = STATE_SLOTS - 1; i >= 0; i--) begin
			if (SCNT_W'(i) < st_used_q) begin
				if (st_tab_q[i] == key_a) begin
					sa_hit = 1'b1;
					sa_idx = SIDX_W'(i);
				end
				if (st_tab_q[i] == item_q.next_state_code)
					sb_hit = 1'b1;
			end
		end
	end

	always_comb begin
		e_hit = 1'b0;
		e_idx = '0;
		for (int i = EVENT_SLOTS - 1; i >= 0; i--) begin
			if (ECNT_W'(i) < ev_used_q && ev_tab_q[i] == item_q.event_code) begin
				e_hit = 1'b1;
				e_idx = EIDX_W'(i);
			end
		end
	end

	assign tr_addr = {sa_idx, e_idx};

	// full when used count reaches the limit clamped to the slot count
	assign st_full = (int'(st_used_q) >= int'(st_lim_q)) || (int'(st_used_q) >= STATE_SLOTS);
	assign ev_full = (int'(ev_used_q) >= int'(ev_lim_q)) || (int'(ev_used_q) >= EVENT_SLOTS);

	always_comb begin
		res_d              = '0;
		res_d.status       = RS_DONE;
		res_d.machine_id   = inst_q;
		pres_d             = present_q;
		st_wr              = 1'b0;
		ev_wr              = 1'b0;
		tr_wr              = 1'b0;
		case (item_q.opcode)
			OP_REG_STATE: begin
				if (!sa_hit && st_full) begin
					res_d.status = RS_FULL;
				end else begin
					st_wr = !sa_hit;
					if (item_q.make_initial)
						pres_d = item_q.state_code;
				end
			end
			OP_REG_EVENT: begin
				if (!e_hit && ev_full)
					res_d.status = RS_FULL;
				else
					ev_wr = !e_hit;
			end
			OP_PROGRAM: begin
				if (sa_hit && sb_hit && e_hit)
					tr_wr = 1'b1;
				else
					res_d.status = RS_UNKNOWN;
			end
			OP_DELIVER: begin
				res_d.event_echo = item_q.event_code;
				if (!pair_hit_q) begin
					res_d.status = RS_UNKNOWN;
				end else if (!rd_vld_q) begin
					res_d.status = RS_NO_TRANS;
				end else begin
					pres_d             = rd_q.next;
					res_d.action_fired = rd_q.act_en;
					res_d.fired_action = ACT_IO_W'(rd_q.act);
				end
			end
			default: ;
		endcase
		res_d.present_id = pres_d;
	end

	// control state and config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_lim_q  <= LIM_W'(16);
			ev_lim_q  <= LIM_W'(16);
			inst_q    <= '0;
			st_used_q <= '0;
			ev_used_q <= '0;
			present_q <= '0;
			tr_vld_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_STATE_LIMIT: st_lim_q <= cfg_data[LIM_W-1:0];
					CFG_EVENT_LIMIT: ev_lim_q <= cfg_data[LIM_W-1:0];
					CFG_INSTANCE_ID: inst_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				present_q <= pres_d;
				if (st_wr)
					st_used_q <= st_used_q + SCNT_W'(1);
				if (ev_wr)
					ev_used_q <= ev_used_q + ECNT_W'(1);
				if (tr_wr)
					tr_vld_q[tr_addr] <= 1'b1;
			end
		end
	end

	// payload: item, id tables, lookup and result registers
	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= item;
		if (cmd.commit && st_wr)
			st_tab_q[st_used_q[SIDX_W-1:0]] <= item_q.state_code;
		if (cmd.commit && ev_wr)
			ev_tab_q[ev_used_q[EIDX_W-1:0]] <= item_q.event_code;
		if (cmd.issue) begin
			rd_vld_q   <= tr_vld_q[tr_addr];
			pair_hit_q <= sa_hit && e_hit;
		end
		if (cmd.commit)
			res_q <= res_d;
	end

	// transition memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.commit && tr_wr)
			tr_mem[tr_addr] <= '{act_en: item_q.has_action,
				act: item_q.has_action ? ACTION_BITS'(item_q.action_code) : '0,
				next: item_q.next_state_code};
		if (cmd.issue)
			rd_q <= tr_mem[tr_addr];
	end

endmodule

// ===== rtl/core/programmable_table_fsm_engine.sv =====
// Top level of the programmable table FSM engine: controller plus datapath.
// Depends on ptfe_pkg, ptfe_if (interfaces), ptfe_ctrl, ptfe_dp.
//
//  channel  | dir | transfer when        | carries
//  ---------+-----+----------------------+-------------------------------------
//  in_ch    | in  | valid & ready        | opcode, ids, make_initial, action
//  out_ch   | out | valid & ready        | status, present_id, action, echo
//  cfg_ch   | in  | valid & ready        | index (0..2), data
//
// Register/program opcodes go through accept, then id match and commit;
// deliver goes through accept, id match plus transition memory read, then
// commit. The single registered read port of the transition memory sets the
// extra step for deliver.
// One result register parts the sides: the next item is accepted while a
// result still waits; the commit stalls only while that register is held.
// Reset clears id counts, present state, transition valid bits, instance id
// and sets limits to 16; cfg writes are always taken (cfg_ch.ready tied high).
module programmable_table_fsm_engine (
	input  logic        clk,
	input  logic        arst_n,
	ptfe_in_if.sink     in_ch,
	ptfe_out_if.source  out_ch,
	ptfe_cfg_if.sink    cfg_ch
);
	import ptfe_pkg::*;

	cmd_t    cmd;
	sts_t    sts;
	item_t   item;
	result_t res;
	logic    cfg_we;

	// pack the input transfer into one record
	always_comb begin
		item.opcode          = op_t'(in_ch.opcode);
		item.state_code      = in_ch.state_code;
		item.next_state_code = in_ch.next_state_code;
		item.event_code      = in_ch.event_code;
		item.make_initial    = in_ch.make_initial;
		item.has_action      = in_ch.has_action;
		item.action_code     = in_ch.action_code;
	end

	assign cfg_ch.ready = 1'b1;
	assign cfg_we       = cfg_ch.valid;

	ptfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ptfe_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_ch.index),
		.cfg_data (cfg_ch.data),
		.res      (res)
	);

	// unpack the result register onto the output channel
	assign out_ch.status        = res.status;
	assign out_ch.present_id    = res.present_id;
	assign out_ch.action_fired  = res.action_fired;
	assign out_ch.fired_action  = res.fired_action;
	assign out_ch.machine_id    = res.machine_id;
	assign out_ch.event_echo    = res.event_echo;

endmodule

// ===== bench/tb_programmable_table_fsm_engine.sv =====
// Self-checking bench for the programmable table FSM engine: directed and random
// opcode streams, config phases, random back-pressure, scoreboard against a predictor.
// Depends on ptfe_pkg, ptfe_if and programmable_table_fsm_engine.
`timescale 1ns / 100ps

module tb_programmable_table_fsm_engine;
	import ptfe_pkg::*;

	localparam int TAB_STATE   = 0;
	localparam int TAB_EVENT   = 1;
	localparam int TAB_MAX     = (STATE_SLOTS > EVENT_SLOTS) ? STATE_SLOTS : EVENT_SLOTS;
	localparam int POOL_SIZE   = 20;
	localparam int MAX_REPORTS = 10;
	// quietest correct stretch is the long receiver hold plus a few bursts
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 250;
	localparam int NUM_PHASES  = 8;

	// one transition memory entry as the predictor keeps it
	typedef struct {
		bit          live;
		bit          act_en;
		logic [31:0] nxt;
		logic [15:0] act;
	} arc_t;

	// Predictor plus queue of expected results. Items are noted in transfer
	// order, results are checked against the oldest expectation.
	class fsm_scoreboard;
		logic [ID_W-1:0]  ids [2][TAB_MAX];
		int               cnt [2];
		logic [LIM_W-1:0] lim [2];
		logic [ID_W-1:0]  inst_id;
		logic [ID_W-1:0]  cur_state;
		arc_t             arcs [TR_DEPTH];
		result_t          pending [$];
		int               mismatches;
		int               results_seen;

		function new();
			cnt[TAB_STATE] = 0;
			cnt[TAB_EVENT] = 0;
			lim[TAB_STATE] = LIM_W'(STATE_SLOTS);
			lim[TAB_EVENT] = LIM_W'(EVENT_SLOTS);
			inst_id = '0;
			cur_state = '0;
			mismatches = 0;
			results_seen = 0;
			foreach (arcs[k])
				arcs[k].live = 1'b0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [ID_W-1:0] d);
			case (idx)
				CFG_STATE_LIMIT: lim[TAB_STATE] = d[LIM_W-1:0];
				CFG_EVENT_LIMIT: lim[TAB_EVENT] = d[LIM_W-1:0];
				CFG_INSTANCE_ID: inst_id = d;
				default: ;
			endcase
		endfunction

		// first match among used slots only
		function int lookup(int t, logic [ID_W-1:0] id);
			for (int k = 0; k < cnt[t]; k++)
				if (ids[t][k] == id)
					return k;
			return -1;
		endfunction

		function status_t enroll(int t, logic [ID_W-1:0] id);
			int slots;
			int eff;
			slots = (t == TAB_STATE) ? STATE_SLOTS : EVENT_SLOTS;
			eff = (int'(lim[t]) > slots) ? slots : int'(lim[t]);
			if (lookup(t, id) >= 0)
				return RS_DONE;
			if (cnt[t] >= eff)
				return RS_FULL;
			ids[t][cnt[t]] = id;
			cnt[t]++;
			return RS_DONE;
		endfunction

		function void note_item(item_t it);
			result_t     r;
			int          si;
			int          ni;
			int          ei;
			int          slot;
			logic [15:0] amask;
			r = '0;
			r.status = RS_DONE;
			amask = (16'd1 << ACTION_BITS) - 16'd1;
			case (it.opcode)
				OP_REG_STATE: begin
					r.status = enroll(TAB_STATE, it.state_code);
					if (r.status == RS_DONE && it.make_initial)
						cur_state = it.state_code;
				end
				OP_REG_EVENT: begin
					r.status = enroll(TAB_EVENT, it.event_code);
				end
				OP_PROGRAM: begin
					si = lookup(TAB_STATE, it.state_code);
					ni = lookup(TAB_STATE, it.next_state_code);
					ei = lookup(TAB_EVENT, it.event_code);
					if (si < 0 || ni < 0 || ei < 0) begin
						r.status = RS_UNKNOWN;
					end else begin
						slot = si * EVENT_SLOTS + ei;
						arcs[slot].live = 1'b1;
						arcs[slot].nxt = it.next_state_code;
						arcs[slot].act_en = it.has_action;
						arcs[slot].act = it.has_action ? ({8'd0, it.action_code} & amask) : '0;
					end
				end
				default: begin
					r.event_echo = it.event_code;
					ei = lookup(TAB_EVENT, it.event_code);
					si = lookup(TAB_STATE, cur_state);
					if (ei < 0 || si < 0) begin
						r.status = RS_UNKNOWN;
					end else begin
						slot = si * EVENT_SLOTS + ei;
						if (!arcs[slot].live) begin
							r.status = RS_NO_TRANS;
						end else begin
							if (arcs[slot].act_en) begin
								r.action_fired = 1'b1;
								r.fired_action = arcs[slot].act[7:0];
							end
							cur_state = arcs[slot].nxt;
						end
					end
				end
			endcase
			r.present_id = cur_state;
			r.machine_id = inst_id;
			pending.push_back(r);
		endfunction

		function void flag(string msg);
			if (mismatches < MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endfunction

		function void cmp(string fld, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				flag($sformatf("result %0d %s expected %h got %h", results_seen, fld, want, got));
		endfunction

		function void check_result(result_t got);
			result_t want;
			results_seen++;
			if (pending.size() == 0) begin
				flag($sformatf("result %0d arrived with no item outstanding", results_seen));
				return;
			end
			want = pending.pop_front();
			cmp("status", 32'(want.status), 32'(got.status));
			cmp("present_id", want.present_id, got.present_id);
			cmp("action_fired", 32'(want.action_fired), 32'(got.action_fired));
			cmp("fired_action", 32'(want.fired_action), 32'(got.fired_action));
			cmp("machine_id", want.machine_id, got.machine_id);
			cmp("event_echo", want.event_echo, got.event_echo);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	ptfe_in_if  in_ch ();
	ptfe_out_if out_ch ();
	ptfe_cfg_if cfg_ch ();

	programmable_table_fsm_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	fsm_scoreboard   sb;
	logic [ID_W-1:0] id_pool [2][POOL_SIZE];
	bit              in_idle;
	bit              out_idle;
	int              long_hold;
	int              quiet_cycles;
	bit              timed_out;

	always #1 clk = ~clk;

	// Monitor: every transfer is seen at the rising edge, before the block's
	// own updates land, so sampling order within the step does not matter.
	always @(posedge clk) begin : monitor
		item_t   seen;
		result_t got;
		bit      moved;
		moved = 1'b0;
		if (cfg_ch.valid && cfg_ch.ready) begin
			sb.write_reg(cfg_idx_t'(cfg_ch.index), cfg_ch.data);
			moved = 1'b1;
		end
		if (out_ch.valid && out_ch.ready) begin
			got.status        = status_t'(out_ch.status);
			got.present_id    = out_ch.present_id;
			got.action_fired  = out_ch.action_fired;
			got.fired_action  = out_ch.fired_action;
			got.machine_id    = out_ch.machine_id;
			got.event_echo    = out_ch.event_echo;
			sb.check_result(got);
			moved = 1'b1;
		end
		if (in_ch.valid && in_ch.ready) begin
			seen.opcode          = op_t'(in_ch.opcode);
			seen.state_code      = in_ch.state_code;
			seen.next_state_code = in_ch.next_state_code;
			seen.event_code      = in_ch.event_code;
			seen.make_initial    = in_ch.make_initial;
			seen.has_action      = in_ch.has_action;
			seen.action_code     = in_ch.action_code;
			sb.note_item(seen);
			moved = 1'b1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
	end

	// Result side: ready changes on the falling edge only. Random stall bursts
	// when enabled; a long hold request from the stimulus side backs the block
	// up until it stops taking items.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold > 0) begin
				stall_left = long_hold;
				long_hold = 0;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (out_idle && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 12);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic item_t mk_item(op_t op, logic [ID_W-1:0] s, logic [ID_W-1:0] n,
			logic [ID_W-1:0] e, logic mi, logic ha, logic [ACT_IO_W-1:0] ac);
		item_t it;
		it.opcode          = op;
		it.state_code      = s;
		it.next_state_code = n;
		it.event_code      = e;
		it.make_initial    = mi;
		it.has_action      = ha;
		it.action_code     = ac;
		return it;
	endfunction

	// Mostly ids the engine already holds, then the pool, rarely anything at all.
	function automatic logic [ID_W-1:0] pick_id(int t);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60 && sb.cnt[t] > 0)
			return sb.ids[t][$urandom_range(0, sb.cnt[t] - 1)];
		if (r < 92)
			return id_pool[t][$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	function automatic item_t rand_item();
		item_t it;
		int    r;
		r = $urandom_range(0, 99);
		if (r < 20)
			it.opcode = OP_REG_STATE;
		else if (r < 32)
			it.opcode = OP_REG_EVENT;
		else if (r < 60)
			it.opcode = OP_PROGRAM;
		else
			it.opcode = OP_DELIVER;
		it.state_code      = pick_id(TAB_STATE);
		it.next_state_code = pick_id(TAB_STATE);
		it.event_code      = pick_id(TAB_EVENT);
		// programming out of the present state keeps deliveries walking the graph
		if (it.opcode == OP_PROGRAM && $urandom_range(0, 1) == 0)
			it.state_code = sb.cur_state;
		it.make_initial = ($urandom_range(0, 3) == 0);
		it.has_action   = 1'($urandom_range(0, 1));
		it.action_code  = ACT_IO_W'($urandom_range(0, 255));
		return it;
	endfunction

	// Called on a falling edge, returns on the falling edge after the transfer.
	task automatic send_item(input item_t it);
		if (in_idle && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		in_ch.valid           <= 1'b1;
		in_ch.opcode          <= it.opcode;
		in_ch.state_code      <= it.state_code;
		in_ch.next_state_code <= it.next_state_code;
		in_ch.event_code      <= it.event_code;
		in_ch.make_initial    <= it.make_initial;
		in_ch.has_action      <= it.has_action;
		in_ch.action_code     <= it.action_code;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	// Stop offering, let every outstanding result come back, then let the pipeline drain.
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	// Only called with the block idle. cfg ready is expected high but we
	// still wait for the handshake.
	task automatic apply_settings(logic [31:0] slim, logic [31:0] elim, logic [31:0] inst);
		cfg_idx_t    regs [3] = '{CFG_STATE_LIMIT, CFG_EVENT_LIMIT, CFG_INSTANCE_ID};
		logic [31:0] vals [3];
		vals[0] = slim;
		vals[1] = elim;
		vals[2] = inst;
		for (int k = 0; k < 3; k++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[k];
			cfg_ch.data  <= vals[k];
			do @(posedge clk); while (!cfg_ch.ready);
			@(negedge clk);
		end
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_stimulus();
		logic [31:0] ph_slim [NUM_PHASES] = '{0, 1, 32'hFFFF_FFE5, 16, 31, 9, 0, 16};
		logic [31:0] ph_elim [NUM_PHASES] = '{0, 3, 16, 16, 31, 17, 0, 16};
		int          ph_items [NUM_PHASES] = '{120, 180, 200, 300, 260, 250, 250, 260};
		bit          ph_in_idle [NUM_PHASES] = '{1, 1, 1, 0, 1, 0, 1, 0};
		bit          ph_out_idle [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1, 0};
		logic [31:0] slim;
		logic [31:0] elim;
		logic [31:0] inst;

		// Directed opening: two slots per table so full tables come quickly.
		in_idle  = 1'b1;
		out_idle = 1'b1;
		apply_settings(2, 2, 32'hFFFF_FFFF);
		// present state not registered yet
		send_item(mk_item(OP_DELIVER, 0, 0, 32'h5, 0, 0, 0));
		send_item(mk_item(OP_REG_STATE, 32'h0, 0, 0, 1, 0, 0));
		send_item(mk_item(OP_REG_STATE, 32'hFFFF_FFFF, 0, 0, 0, 1, 8'hFF));
		// known id: no new slot, make_initial still takes effect
		send_item(mk_item(OP_REG_STATE, 32'hFFFF_FFFF, 0, 0, 1, 0, 0));
		// state table full: make_initial ignored
		send_item(mk_item(OP_REG_STATE, 32'h1234_5678, 0, 0, 1, 0, 0));
		send_item(mk_item(OP_REG_EVENT, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send_item(mk_item(OP_REG_EVENT, 0, 0, 32'h0, 0, 0, 0));
		send_item(mk_item(OP_REG_EVENT, 0, 0, 32'hA5A5_A5A5, 0, 0, 0));
		// unknown event, then unknown source state
		send_item(mk_item(OP_PROGRAM, 32'h0, 32'hFFFF_FFFF, 32'hDEAD, 0, 1, 8'h55));
		send_item(mk_item(OP_PROGRAM, 32'h1234_5678, 32'h0, 32'h0, 0, 1, 8'hAA));
		send_item(mk_item(OP_PROGRAM, 32'h0, 32'h1234_5678, 32'h0, 0, 1, 8'hAA));
		send_item(mk_item(OP_PROGRAM, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 0, 1, 8'hFF));
		// no action: stored action must read back as zero
		send_item(mk_item(OP_PROGRAM, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 8'h5A));
		// pair known but nothing programmed
		send_item(mk_item(OP_DELIVER, 32'hFFFF_FFFF, 0, 32'h0, 1, 1, 8'hFF));
		send_item(mk_item(OP_DELIVER, 0, 0, 32'hA5A5_A5A5, 0, 0, 0));
		send_item(mk_item(OP_DELIVER, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send_item(mk_item(OP_DELIVER, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		// reprogram same pair, action zero but enabled
		send_item(mk_item(OP_PROGRAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0));
		send_item(mk_item(OP_DELIVER, 0, 0, 32'hFFFF_FFFF, 0, 0, 0));
		send_item(mk_item(OP_REG_STATE, 32'h0, 0, 0, 1, 0, 0));
		send_item(mk_item(OP_PROGRAM, 32'h0, 32'hFFFF_FFFF, 32'h0, 0, 1, 8'h81));
		send_item(mk_item(OP_DELIVER, 0, 0, 32'h0, 0, 0, 0));

		// Random phases. Tables only grow, so limits start low and open up;
		// limit 0 keeps everything full, 31 saturates at the slot count.
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			slim = ph_slim[p];
			elim = ph_elim[p];
			inst = (p == 0) ? 32'h0 : $urandom;
			if (p == 6) begin
				slim = $urandom_range(0, 31);
				elim = $urandom_range(0, 31);
			end
			apply_settings(slim, elim, inst);
			in_idle  = ph_in_idle[p];
			out_idle = ph_out_idle[p];
			// back the block up while the sender keeps offering
			if (p == 3)
				long_hold = LONG_HOLD;
			repeat (ph_items[p])
				send_item(rand_item());
		end
		settle();
	endtask

	initial begin
		sb = new();
		timed_out = 1'b0;
		quiet_cycles = 0;
		long_hold = 0;
		in_idle = 1'b0;
		out_idle = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = '0;
		in_ch.state_code = '0;
		in_ch.next_state_code = '0;
		in_ch.event_code = '0;
		in_ch.make_initial = 1'b0;
		in_ch.has_action = 1'b0;
		in_ch.action_code = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_STATE_LIMIT;
		cfg_ch.data = '0;
		foreach (id_pool[t, k])
			id_pool[t][k] = (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		fork
			run_stimulus();
			begin
				wait (quiet_cycles >= QUIET_LIMIT);
				timed_out = 1'b1;
				$display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
			end
		join_any

		if (!timed_out && sb.pending.size() != 0)
			$display("%0d expected results never arrived", sb.pending.size());
		if (!timed_out && sb.mismatches == 0 && sb.pending.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/ptfe_pkg.sv
rtl/core/ptfe_if.sv
rtl/core/ptfe_ctrl.sv
rtl/core/ptfe_dp.sv
rtl/core/programmable_table_fsm_engine.sv
bench/tb_programmable_table_fsm_engine.sv
